// File: hw/rtl/rco_pkg.sv
// Shared types and constants for the ramp-compare ohmmeter.
// Used by the top level and its port checker; no dependencies.
package rco_pkg;

  localparam int CODE_BITS = 12;
  localparam int REG_CODE_W = 12;
  localparam int SCALE_W = 20;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_INDEX_W = 2;
  // Denominator width: wide enough for any code or offset, plus sign room
  localparam int CMP_W = ((CODE_BITS > REG_CODE_W) ? CODE_BITS : REG_CODE_W) + 1;
  localparam int OHMS_W = 16;
  localparam int DIGIT_W = 4;
  localparam int NUM_DIGITS = 5;
  localparam int BCD_W = DIGIT_W * NUM_DIGITS;
  localparam int DIV_STEPS = SCALE_W;
  localparam int BCD_STEPS = OHMS_W;
  localparam int STEP_CNT_W = $clog2(DIV_STEPS + 1);

  localparam int IN_TDATA_W = 8;
  localparam int IN_TUSER_W = 1;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 2;

  typedef logic [CODE_BITS-1:0] code_t;
  typedef logic [REG_CODE_W-1:0] reg_code_t;
  typedef logic [SCALE_W-1:0] scale_t;
  typedef logic [CMP_W-1:0] cmp_t;
  typedef logic [OHMS_W-1:0] ohms_t;
  typedef logic [BCD_W-1:0] bcd_t;
  typedef logic [15:0] dac_word_t;
  typedef logic [STEP_CNT_W-1:0] step_cnt_t;

  localparam dac_word_t DAC_PREFIX = 16'h4000;
  localparam ohms_t OHMS_MAX = 16'hFFFF;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_RAMP_START = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RAMP_END = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_NUM = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_OFFSET = 2'd3;

  // Reset values of the configuration registers
  localparam reg_code_t RAMP_START_RST = 12'd0;
  localparam reg_code_t RAMP_END_RST = 12'hFFF;
  localparam scale_t SCALE_NUM_RST = 20'd204022;
  localparam reg_code_t CODE_OFFSET_RST = 12'd1501;

  // Input op codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

endpackage

// File: hw/rtl/ramp_compare_ohmmeter_top.sv
// Ramp-compare ohmmeter: ramp sequencer, bit-serial divider and digit converter.
// Depends on rco_pkg for widths, register indexes and constants.
//
// Usage:
//   Input stream (in_*): tuser[0] is the op (0 start, 1 comparator sample),
//   tdata[0] is the comparator flag. Output stream (out_*): one transfer per
//   input item. tlast marks the item that finished the ramp; tuser carries
//   dac_send and reading_valid; tdata carries the DAC word, ohms and digits.
//   Config port: cfg_we writes cfg_wdata into register cfg_index;
//   write only while the block is idle.
// Timing:
//   Start items and ramp steps give their result in the cycle after the accept.
//   A finishing sample with a usable reading latches the denominator, runs
//   the one-bit-per-cycle restoring divider, saturates, runs the
//   shift-and-add-3 digit conversion and registers the result once the output is free.
//   A finish without a usable reading gives its result in the cycle after the accept.
//   The block takes one item at a time; in_tready is low until it registers a reading.
// Reset: rst_n low clears the ramp, the sequencer and the output valid, and
//   loads the calibration defaults into the registers.
// Stall: a result waits in the output register until out_tready; the next
//   item is taken in the cycle that result transfers.
module ramp_compare_ohmmeter_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rco_pkg::IN_TDATA_W-1:0]      in_tdata,   // [0] comparator_tripped
  input  logic [rco_pkg::IN_TUSER_W-1:0]      in_tuser,   // [0] op
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [15:0] dac_word, [31:16] ohms, [35:32] digit_ten_thousands,
  // [39:36] digit_thousands, [43:40] digit_hundreds, [47:44] digit_tens,
  // [51:48] digit_ones, [55:52] zero
  output logic [rco_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [rco_pkg::OUT_TUSER_W-1:0]     out_tuser,  // [0] dac_send, [1] reading_valid
  output logic                                out_tlast,  // done_res
  input  logic                                cfg_we,
  input  logic [rco_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rco_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_SAT  = 3'd2;
  localparam logic [2:0] ST_BCD  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  // Configuration registers
  rco_pkg::reg_code_t ramp_start_r;
  rco_pkg::reg_code_t ramp_end_r;
  rco_pkg::scale_t    scale_num_r;
  rco_pkg::reg_code_t code_offset_r;

  // Sequencer state
  logic [2:0]         state_r, state_nxt;
  logic               running_r, running_nxt;
  rco_pkg::code_t     code_r, code_nxt;
  rco_pkg::step_cnt_t cnt_r, cnt_nxt;

  // Datapath registers: divider, then digit converter
  rco_pkg::cmp_t      den_r, den_nxt;
  rco_pkg::cmp_t      rem_r, rem_nxt;
  rco_pkg::scale_t    quo_r, quo_nxt;
  rco_pkg::ohms_t     ohms_r, ohms_nxt;
  rco_pkg::ohms_t     bin_r, bin_nxt;
  rco_pkg::bcd_t      bcd_r, bcd_nxt;

  // Output register
  logic                               out_valid_r, out_valid_nxt;
  logic [rco_pkg::OUT_TDATA_W-1:0]    out_data_r, out_data_nxt;
  logic [rco_pkg::OUT_TUSER_W-1:0]    out_user_r, out_user_nxt;
  logic                               out_last_r, out_last_nxt;

  logic               in_xfer;
  logic               out_free;
  logic               op;
  logic               tripped;
  rco_pkg::code_t     start_code;
  rco_pkg::code_t     end_code;
  rco_pkg::cmp_t      code_ext;
  rco_pkg::cmp_t      offset_ext;
  logic               reading_ok;
  logic [rco_pkg::CMP_W:0] trial;
  logic               trial_ge;
  rco_pkg::bcd_t      bcd_adj;
  rco_pkg::dac_word_t dac_word;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE) && out_free;
  assign in_xfer    = in_tvalid && in_tready;
  assign op         = in_tuser[0];
  assign tripped    = in_tdata[0];

  assign start_code = rco_pkg::code_t'(ramp_start_r);
  assign end_code   = rco_pkg::code_t'(ramp_end_r);
  assign code_ext   = rco_pkg::cmp_t'(code_r);
  assign offset_ext = rco_pkg::cmp_t'(code_offset_r);
  assign reading_ok = (code_r != start_code) && (code_r != end_code) &&
                      (code_ext > offset_ext);
  assign dac_word   = rco_pkg::DAC_PREFIX | rco_pkg::dac_word_t'(code_r);

  // One restoring-division step
  assign trial    = {rem_r, quo_r[rco_pkg::SCALE_W-1]};
  assign trial_ge = trial >= {1'b0, den_r};

  // Add-3 correction on every digit before the shift
  always_comb begin
    for (int d = 0; d < rco_pkg::NUM_DIGITS; d++) begin
      if (bcd_r[d*rco_pkg::DIGIT_W +: rco_pkg::DIGIT_W] >= 4'd5) begin
        bcd_adj[d*rco_pkg::DIGIT_W +: rco_pkg::DIGIT_W] =
          bcd_r[d*rco_pkg::DIGIT_W +: rco_pkg::DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[d*rco_pkg::DIGIT_W +: rco_pkg::DIGIT_W] =
          bcd_r[d*rco_pkg::DIGIT_W +: rco_pkg::DIGIT_W];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    running_nxt   = running_r;
    code_nxt      = code_r;
    cnt_nxt       = cnt_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    ohms_nxt      = ohms_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_user_nxt  = '0;
          out_last_nxt  = 1'b0;
          if (op == rco_pkg::OP_START) begin
            code_nxt     = start_code;
            running_nxt  = 1'b1;
            out_data_nxt[15:0] = rco_pkg::DAC_PREFIX | rco_pkg::dac_word_t'(start_code);
            out_user_nxt[0]    = 1'b1;
          end else if (running_r) begin
            if (!tripped && (code_r < end_code)) begin
              out_data_nxt[15:0] = dac_word;
              out_user_nxt[0]    = 1'b1;
              code_nxt           = code_r + 1'b1;
            end else begin
              running_nxt = 1'b0;
              if (reading_ok) begin
                // hold the result back until the divide finishes
                out_valid_nxt = 1'b0;
                den_nxt       = code_ext - offset_ext;
                rem_nxt       = '0;
                quo_nxt       = scale_num_r;
                cnt_nxt       = rco_pkg::step_cnt_t'(rco_pkg::DIV_STEPS - 1);
                state_nxt     = ST_DIV;
              end else begin
                out_last_nxt = 1'b1;
              end
            end
          end
        end
      end
      ST_DIV: begin
        if (trial_ge) begin
          rem_nxt = rco_pkg::cmp_t'(trial - {1'b0, den_r});
        end else begin
          rem_nxt = trial[rco_pkg::CMP_W-1:0];
        end
        quo_nxt = {quo_r[rco_pkg::SCALE_W-2:0], trial_ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: begin
        if (quo_r > rco_pkg::scale_t'(rco_pkg::OHMS_MAX)) begin
          ohms_nxt = rco_pkg::OHMS_MAX;
          bin_nxt  = rco_pkg::OHMS_MAX;
        end else begin
          ohms_nxt = quo_r[rco_pkg::OHMS_W-1:0];
          bin_nxt  = quo_r[rco_pkg::OHMS_W-1:0];
        end
        bcd_nxt   = '0;
        cnt_nxt   = rco_pkg::step_cnt_t'(rco_pkg::BCD_STEPS - 1);
        state_nxt = ST_BCD;
      end
      ST_BCD: begin
        bcd_nxt = {bcd_adj[rco_pkg::BCD_W-2:0], bin_r[rco_pkg::OHMS_W-1]};
        bin_nxt = {bin_r[rco_pkg::OHMS_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt        = '0;
          out_data_nxt[31:16] = ohms_r;
          out_data_nxt[35:32] = bcd_r[19:16];
          out_data_nxt[39:36] = bcd_r[15:12];
          out_data_nxt[43:40] = bcd_r[11:8];
          out_data_nxt[47:44] = bcd_r[7:4];
          out_data_nxt[51:48] = bcd_r[3:0];
          out_user_nxt        = 2'b10;
          out_last_nxt        = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      running_r     <= 1'b0;
      code_r        <= '0;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
      ramp_start_r  <= rco_pkg::RAMP_START_RST;
      ramp_end_r    <= rco_pkg::RAMP_END_RST;
      scale_num_r   <= rco_pkg::SCALE_NUM_RST;
      code_offset_r <= rco_pkg::CODE_OFFSET_RST;
    end else begin
      state_r     <= state_nxt;
      running_r   <= running_nxt;
      code_r      <= code_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          rco_pkg::REG_RAMP_START:  ramp_start_r  <= cfg_wdata[rco_pkg::REG_CODE_W-1:0];
          rco_pkg::REG_RAMP_END:    ramp_end_r    <= cfg_wdata[rco_pkg::REG_CODE_W-1:0];
          rco_pkg::REG_SCALE_NUM:   scale_num_r   <= cfg_wdata[rco_pkg::SCALE_W-1:0];
          rco_pkg::REG_CODE_OFFSET: code_offset_r <= cfg_wdata[rco_pkg::REG_CODE_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    ohms_r     <= ohms_nxt;
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

// File: hw/rtl/rco_checker.sv
// Port-level checker for the ramp-compare ohmmeter, bound to the top level.
// Depends on rco_pkg for the stream widths.
module rco_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [rco_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [rco_pkg::OUT_TUSER_W-1:0] out_tuser,
  input logic                            out_tlast
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // A usable reading only comes with a finished ramp
  a_valid_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast && !out_tuser[0])
    else $error("reading_valid without done_res");

  // A DAC send never finishes the ramp and carries the DAC prefix
  a_send_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tlast && (out_tdata[15:12] == 4'h4))
    else $error("dac_send with done_res or bad prefix");

  // Reading fields stay zero without a usable reading
  a_no_reading_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tdata[55:16] == '0)
    else $error("reading fields set without reading_valid");

  // DAC word stays zero when nothing is sent
  a_no_send_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[15:0] == '0)
    else $error("dac_word set without dac_send");

endmodule

bind ramp_compare_ohmmeter_top rco_checker u_rco_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// File: dv/tb.sv
// Self-checking bench for ramp_compare_ohmmeter_top: directed ramps, then random
// ramp sequences under several calibration settings and stall patterns.
// Depends on rco_pkg for port widths, op codes and register indexes.
module tb;

  localparam int CYCLE_LIMIT = 500000;
  localparam rco_pkg::dac_word_t DAC_CTRL = 16'h4000;

  typedef struct packed {
    rco_pkg::dac_word_t dac_word;
    logic dac_send;
    logic done;
    logic valid;
    rco_pkg::ohms_t ohms;
    logic [4:0][3:0] digits;  // [0] ones .. [4] ten thousands
  } reading_t;

  typedef struct {
    logic op;
    logic tripped;
    bit drain;  // hold this item until every pending reading is back
  } meter_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [rco_pkg::IN_TDATA_W-1:0] in_tdata = '0;   // [0] comparator_tripped
  logic [rco_pkg::IN_TUSER_W-1:0] in_tuser = '0;   // [0] op
  logic out_tvalid;
  logic out_tready = 1'b0;
  // [15:0] dac_word, [31:16] ohms, [35:32] .. [51:48] digits ten thousands to ones
  logic [rco_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [rco_pkg::OUT_TUSER_W-1:0] out_tuser;      // [0] dac_send, [1] reading_valid
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [rco_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [rco_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Calibration shadow and ramp state of the predictor
  rco_pkg::reg_code_t start_r = 12'd0;
  rco_pkg::reg_code_t end_r = 12'd4095;
  rco_pkg::scale_t scale_r = 20'd204022;
  rco_pkg::reg_code_t offset_r = 12'd1501;
  rco_pkg::code_t code_q = '0;
  logic running_q = 1'b0;

  meter_item_t pending_items[$];
  reading_t readings_due[$];
  int errors = 0;
  int cycles = 0;
  int send_idle = 9;
  int recv_idle = 67;

  ramp_compare_ohmmeter_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic reading_t advance_meter(logic op, logic tripped);
    reading_t r;
    logic [19:0] quot;
    int unsigned v;
    r = '0;
    if (op == rco_pkg::OP_START) begin
      code_q = rco_pkg::code_t'(start_r);
      running_q = 1'b1;
      r.dac_word = DAC_CTRL | {4'h0, code_q};
      r.dac_send = 1'b1;
    end else if (running_q) begin
      if (!tripped && code_q < rco_pkg::code_t'(end_r)) begin
        r.dac_word = DAC_CTRL | {4'h0, code_q};
        r.dac_send = 1'b1;
        code_q = code_q + 1'b1;
      end else begin
        running_q = 1'b0;
        r.done = 1'b1;
        if (code_q != start_r && code_q != end_r && code_q > offset_r) begin
          quot = scale_r / {8'd0, code_q - offset_r};
          r.ohms = (quot > 20'd65535) ? 16'hFFFF : quot[15:0];
          r.valid = 1'b1;
          v = r.ohms;
          for (int i = 0; i < 5; i++) begin
            r.digits[i] = 4'(v % 10);
            v = v / 10;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Driver: hold an offered transfer until accepted, predict on accept
  always @(posedge clk) begin
    meter_item_t item;
    logic offer;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        readings_due.push_back(advance_meter(in_tuser[0], in_tdata[0]));
      if (!in_tvalid || in_tready) begin
        offer = 1'b0;
        if (pending_items.size() != 0 && !(pending_items[0].drain && readings_due.size() != 0)
            && $urandom_range(99) >= send_idle) begin
          item = pending_items.pop_front();
          offer = 1'b1;
          in_tuser <= item.op;
          in_tdata <= rco_pkg::IN_TDATA_W'(item.tripped);
        end
        in_tvalid <= offer;
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    reading_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (readings_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual tdata %h tuser %b tlast %b",
                   $time, out_tdata, out_tuser, out_tlast);
          errors++;
        end else begin
          want = readings_due.pop_front();
          check_field("dac_word", want.dac_word, out_tdata[15:0]);
          check_field("dac_send", want.dac_send, out_tuser[0]);
          check_field("done_res", want.done, out_tlast);
          check_field("reading_valid", want.valid, out_tuser[1]);
          check_field("ohms", want.ohms, out_tdata[31:16]);
          for (int i = 0; i < 5; i++)
            check_field($sformatf("digit 10^%0d", i), want.digits[i], out_tdata[48-4*i +: 4]);
          check_field("tdata pad", 0, out_tdata[55:52]);
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d items and %0d readings outstanding", $time,
               pending_items.size(), readings_due.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic void push_item(logic op, logic tripped, bit drain);
    meter_item_t item;
    item.op = op;
    item.tripped = tripped;
    item.drain = drain;
    pending_items.push_back(item);
  endfunction

  function automatic void queue_ramp(int steps, bit finish);
    push_item(rco_pkg::OP_START, 1'($urandom_range(1)), $urandom_range(99) < 4);
    repeat (steps) push_item(rco_pkg::OP_SAMPLE, 1'b0, 1'b0);
    if (finish)
      push_item(rco_pkg::OP_SAMPLE, 1'b1, 1'b0);
  endfunction

  task automatic settle();
    while (pending_items.size() != 0 || in_tvalid || readings_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [rco_pkg::CFG_INDEX_W-1:0] idx,
                           logic [rco_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rco_pkg::REG_RAMP_START: start_r = data[11:0];
      rco_pkg::REG_RAMP_END: end_r = data[11:0];
      rco_pkg::REG_SCALE_NUM: scale_r = data;
      rco_pkg::REG_CODE_OFFSET: offset_r = data[11:0];
      default: ;
    endcase
  endtask

  // Junk in the upper write bits of the 12-bit registers must be dropped
  task automatic set_config(int s, int e, int sc, int off);
    write_reg(rco_pkg::REG_RAMP_START, rco_pkg::CFG_DATA_W'({$urandom(), 12'(s)}));
    write_reg(rco_pkg::REG_RAMP_END, rco_pkg::CFG_DATA_W'({$urandom(), 12'(e)}));
    write_reg(rco_pkg::REG_SCALE_NUM, rco_pkg::CFG_DATA_W'(sc));
    write_reg(rco_pkg::REG_CODE_OFFSET, rco_pkg::CFG_DATA_W'({$urandom(), 12'(off)}));
  endtask

  task automatic random_config(int sc);
    int s;
    int off;
    s = $urandom_range(4095 - 64);
    off = (s >= 16) ? s - 16 + $urandom_range(32) : $urandom_range(32);
    set_config(s, s + $urandom_range(64), sc, off);
  endtask

  // Mostly well-formed ramps with random length, some cut short, some noise
  task automatic run_traffic(int n);
    int counted;
    int len;
    counted = 0;
    while (counted < n) begin
      if ($urandom_range(99) < 85) begin
        len = ($urandom_range(99) < 75) ? $urandom_range(8) : $urandom_range(60, 9);
        queue_ramp(len, $urandom_range(99) < 85);
        counted += len + 2;
      end else begin
        push_item(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0);
        counted++;
      end
    end
    settle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset calibration: idle samples, finish at the start code, finish below offset
    push_item(rco_pkg::OP_SAMPLE, 1'b0, 1'b0);
    push_item(rco_pkg::OP_SAMPLE, 1'b1, 1'b0);
    push_item(rco_pkg::OP_START, 1'b1, 1'b0);
    push_item(rco_pkg::OP_SAMPLE, 1'b1, 1'b0);
    push_item(rco_pkg::OP_START, 1'b0, 1'b0);
    push_item(rco_pkg::OP_SAMPLE, 1'b0, 1'b0);
    push_item(rco_pkg::OP_SAMPLE, 1'b1, 1'b0);
    settle();

    // Saturated quotient, ramp running into its end code, restart while running
    set_config(1500, 1506, 20'hFFFFF, 1501);
    queue_ramp(2, 1'b1);
    queue_ramp(6, 1'b0);
    push_item(rco_pkg::OP_SAMPLE, 1'b0, 1'b0);
    push_item(rco_pkg::OP_START, 1'b0, 1'b1);
    queue_ramp(1, 1'b1);
    settle();

    // Zero numerator gives a valid zero reading
    set_config(1, 4095, 0, 0);
    queue_ramp(1, 1'b1);
    settle();

    random_config($urandom_range(20'hFFFFF));
    run_traffic(140);
    set_config(0, 4095, 20'hFFFFF, 0);
    run_traffic(140);

    send_idle = 67;
    recv_idle = 9;
    set_config(4090, 4095, $urandom_range(20'hFFFFF), 4000);
    run_traffic(140);
    set_config(4095, 0, $urandom_range(20'hFFFFF), 0);
    run_traffic(100);

    send_idle = 0;
    recv_idle = 0;
    random_config($urandom_range(20'hFFFFF));
    run_traffic(160);
    random_config($urandom_range(200));
    run_traffic(170);

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
